// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is low
`define GIBMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// value must hold in the cycle after cond
`define GIBMT_ASSERT_HOLD(label, cond, sig, msg) \
  `GIBMT_ASSERT(label, cond |=> $stable(sig), msg)

`endif

// ===== sv/gibmt_pkg.sv =====
`timescale 1ns / 1ps

package gibmt_pkg;

  localparam int RATE_W     = 16;
  localparam int RATE_FRAC  = 4;
  localparam int SP_W       = 24;
  localparam int SP_FRAC    = 8;
  localparam int DUTY_W     = 8;
  localparam int PERIOD_W   = 16;
  localparam int PULSE_W    = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CHUNK_W    = 16;
  localparam int NUM_MOTORS = 4;

  // motor slots
  localparam int MOT_A = 0;
  localparam int MOT_B = 1;
  localparam int MOT_C = 2;
  localparam int MOT_D = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TMR_PERIOD = 2'd3;

  localparam logic [DUTY_W-1:0]   DUTY_OFFSET_RST = 8'd7;
  localparam logic [PERIOD_W-1:0] TMR_PERIOD_RST  = 16'd6666;

  // divide by 100: floor(x * RECIP / 2^RECIP_SHIFT) for x below 2^PROD_W
  localparam int PROD_W      = PERIOD_W + DUTY_W;
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 31;
  localparam int QUOT_W      = PROD_W + RECIP_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP = 25'd21474837;

  localparam logic [0:0] REQ_TICK = 1'b0;
  localparam logic [0:0] REQ_LOAD = 1'b1;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_RATE,
    OP_ANGLE,
    OP_ERR,
    OP_MAC,
    OP_SUM,
    OP_TRIM,
    OP_PULSE,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    logic pos;
    logic neg;
  } trim_t;

  typedef struct packed {
    logic mac_last;
    logic pulse_last;
  } dp_status_t;

  typedef logic [NUM_MOTORS-1:0][DUTY_W-1:0]  duty_vec_t;
  typedef logic [NUM_MOTORS-1:0][PULSE_W-1:0] pulse_vec_t;

  typedef struct packed {
    logic                     req_type;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic [DUTY_W-1:0]        duty_load;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty_a;
    logic [DUTY_W-1:0]  duty_b;
    logic [DUTY_W-1:0]  duty_c;
    logic [DUTY_W-1:0]  duty_d;
    logic [PULSE_W-1:0] pulse_a;
    logic [PULSE_W-1:0] pulse_b;
    logic [PULSE_W-1:0] pulse_c;
    logic [PULSE_W-1:0] pulse_d;
  } out_item_t;

endpackage

// ===== sv/gibmt_in_if.sv =====
`timescale 1ns / 1ps

interface gibmt_in_if;
  logic                valid;
  logic                ready;
  gibmt_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/gibmt_out_if.sv =====
`timescale 1ns / 1ps

interface gibmt_out_if;
  logic                 valid;
  logic                 ready;
  gibmt_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/gibmt_ctrl.sv =====
`timescale 1ns / 1ps

module gibmt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  gibmt_pkg::dp_status_t status_i,
  output gibmt_pkg::dp_op_e     cmd_o
);
  import gibmt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_RATE,
    S_ANGLE,
    S_ERR,
    S_MAC,
    S_SUM,
    S_TRIM,
    S_PULSE,
    S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // a new result may replace the one taken in the same cycle
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= (req_type_i == REQ_LOAD) ? S_LOAD : S_RATE;
          end
        end
        S_LOAD:  state_q <= S_PULSE;
        S_RATE:  state_q <= S_ANGLE;
        S_ANGLE: state_q <= S_ERR;
        S_ERR:   state_q <= S_MAC;
        S_MAC: begin
          if (status_i.mac_last) begin
            state_q <= S_SUM;
          end
        end
        S_SUM:   state_q <= S_TRIM;
        S_TRIM:  state_q <= S_PULSE;
        S_PULSE: begin
          if (status_i.pulse_last) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (state_q)
      S_LOAD:  cmd_o = OP_LOAD;
      S_RATE:  cmd_o = OP_RATE;
      S_ANGLE: cmd_o = OP_ANGLE;
      S_ERR:   cmd_o = OP_ERR;
      S_MAC:   cmd_o = OP_MAC;
      S_SUM:   cmd_o = OP_SUM;
      S_TRIM:  cmd_o = OP_TRIM;
      S_PULSE: cmd_o = OP_PULSE;
      S_DONE:  cmd_o = out_free ? OP_OUT : OP_IDLE;
      default: cmd_o = OP_IDLE;
    endcase
  end

endmodule

// ===== sv/gibmt_axis.sv =====
`timescale 1ns / 1ps

module gibmt_axis #(
  parameter int ACC_WIDTH = 40,
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  gibmt_pkg::dp_op_e                     cmd_i,
  input  logic signed [gibmt_pkg::RATE_W-1:0]   rate_i,
  input  logic signed [gibmt_pkg::SP_W-1:0]     setpoint_i,
  output gibmt_pkg::trim_t                      trim_o,
  output logic                                  mac_last_o
);
  import gibmt_pkg::*;

  // 0.06 in fixed point, rounded
  localparam longint unsigned KDT = ((64'd6 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam int KW   = $clog2(KDT + 1);
  localparam int NC   = (ACC_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int EW   = NC * CHUNK_W;
  localparam int CNTW = (NC > 1) ? $clog2(NC) : 1;
  localparam int MW   = CHUNK_W + 1 + KW + 1;
  localparam int AW   = EW + KW + 1;
  localparam int SW0  = (ACC_WIDTH > AW) ? ACC_WIDTH : AW;
  localparam int SW   = ((SW0 > SP_W + FRAC_BITS - SP_FRAC) ? SW0 :
                         SP_W + FRAC_BITS - SP_FRAC) + 2;

  localparam logic signed [KW:0] KDT_S = {1'b0, KW'(KDT)};
  localparam logic [CNTW-1:0] CNT_TOP = CNTW'(NC - 1);
  localparam logic signed [ACC_WIDTH+1:0] ONE_FX =
    signed'((ACC_WIDTH + 2)'(1) << FRAC_BITS);

  logic signed [ACC_WIDTH-1:0] angle_q, err_q, sum_q;
  logic signed [AW-1:0]        acc_q;
  logic [CNTW-1:0]             cnt_q;

  logic signed [EW-1:0]        err_ext;
  logic [CHUNK_W-1:0]          chunk;
  logic signed [CHUNK_W:0]     mop;
  logic signed [MW-1:0]        mprod;
  logic signed [AW-1:0]        mprod_ext;
  logic signed [SW-1:0]        ang_sum, err_diff, sum_sum;
  logic signed [ACC_WIDTH+1:0] sum_wide;

  function automatic logic signed [ACC_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
    logic [SW-ACC_WIDTH:0] top;
    top = v[SW-1:ACC_WIDTH-1];
    if (&top || ~|top) begin
      return v[ACC_WIDTH-1:0];
    end else if (v[SW-1]) begin
      return {1'b1, {(ACC_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end
  endfunction

  // error times 0.06 goes through the multiplier one chunk a cycle, top chunk first
  assign err_ext = EW'(err_q);
  assign chunk   = err_ext[cnt_q*CHUNK_W +: CHUNK_W];

  always_comb begin
    if (cmd_i == OP_RATE) begin
      mop = {rate_i[RATE_W-1], rate_i};
    end else if (cnt_q == CNT_TOP) begin
      mop = {chunk[CHUNK_W-1], chunk};
    end else begin
      mop = {1'b0, chunk};
    end
  end

  assign mprod     = mop * KDT_S;
  assign mprod_ext = AW'(mprod);

  assign ang_sum  = SW'(angle_q) + SW'(acc_q >>> RATE_FRAC);
  assign err_diff = (SW'(setpoint_i) <<< (FRAC_BITS - SP_FRAC)) - SW'(angle_q);
  assign sum_sum  = SW'(sum_q) + SW'(acc_q >>> FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (cmd_i)
        OP_ANGLE: angle_q <= sat(ang_sum);
        OP_ERR:   cnt_q   <= CNT_TOP;
        OP_MAC: begin
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        OP_SUM:   sum_q   <= sat(sum_sum);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      OP_RATE: acc_q <= mprod_ext;
      OP_ERR:  err_q <= sat(err_diff);
      OP_MAC: begin
        if (cnt_q == CNT_TOP) begin
          acc_q <= mprod_ext;
        end else begin
          acc_q <= (acc_q <<< CHUNK_W) + mprod_ext;
        end
      end
      default: ;
    endcase
  end

  assign sum_wide   = (ACC_WIDTH + 2)'(sum_q);
  assign trim_o.pos = (sum_wide > ONE_FX);
  assign trim_o.neg = (sum_wide < -ONE_FX);
  assign mac_last_o = (cnt_q == '0);

endmodule

// ===== sv/gibmt_duty.sv =====
`timescale 1ns / 1ps

module gibmt_duty (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gibmt_pkg::dp_op_e                   cmd_i,
  input  logic [gibmt_pkg::DUTY_W-1:0]        duty_load_i,
  input  gibmt_pkg::trim_t                    trim_x_i,
  input  gibmt_pkg::trim_t                    trim_y_i,
  input  logic [gibmt_pkg::DUTY_W-1:0]        duty_offset_i,
  input  logic [gibmt_pkg::PERIOD_W-1:0]      tmr_period_i,
  output gibmt_pkg::duty_vec_t                duty_o,
  output gibmt_pkg::pulse_vec_t               pulse_o,
  output logic                                pulse_last_o
);
  import gibmt_pkg::*;

  localparam int PCW = $clog2(NUM_MOTORS + 1);
  localparam int MIW = $clog2(NUM_MOTORS);
  localparam logic [PCW-1:0] PCNT_END = PCW'(NUM_MOTORS);

  duty_vec_t                    duty_q;
  duty_vec_t                    duty_step;
  duty_vec_t                    duty_bound;
  pulse_vec_t                   pulse_q;
  logic [PROD_W-1:0]            prod_q;
  logic [PROD_W-1:0]            prod_d;
  logic [PCW-1:0]               pcnt_q;
  logic [PCW-1:0]               pprev;
  logic [PROD_W+RECIP_W-1:0]    qfull;
  logic [QUOT_W-1:0]            quot;
  logic [PULSE_W-1:0]           pulse_sat;

  // clamp to offset +/- 3; a bound outside 0..255 never hits
  function automatic logic [DUTY_W-1:0] bound(input logic [DUTY_W-1:0] d,
                                              input logic [DUTY_W-1:0] off);
    logic signed [DUTY_W+1:0] v, hi, lo;
    v  = signed'({2'b00, d});
    hi = signed'({2'b00, off}) + 10'sd3;
    lo = signed'({2'b00, off}) - 10'sd3;
    if (v >= hi) begin
      v = hi;
    end
    if (v <= lo) begin
      v = lo;
    end
    return v[DUTY_W-1:0];
  endfunction

  always_comb begin
    duty_step = duty_q;
    if (trim_x_i.pos) begin
      duty_step[MOT_C] = duty_step[MOT_C] + 1'b1;
      duty_step[MOT_A] = duty_step[MOT_A] - 1'b1;
    end
    if (trim_x_i.neg) begin
      duty_step[MOT_A] = duty_step[MOT_A] + 1'b1;
      duty_step[MOT_C] = duty_step[MOT_C] - 1'b1;
    end
    if (trim_y_i.pos) begin
      duty_step[MOT_D] = duty_step[MOT_D] + 1'b1;
      duty_step[MOT_B] = duty_step[MOT_B] - 1'b1;
    end
    if (trim_y_i.neg) begin
      duty_step[MOT_B] = duty_step[MOT_B] + 1'b1;
      duty_step[MOT_D] = duty_step[MOT_D] - 1'b1;
    end
    for (int m = 0; m < NUM_MOTORS; m++) begin
      duty_bound[m] = bound(duty_step[m], duty_offset_i);
    end
  end

  // pulses one motor a cycle: product, then divide by 100 in the next cycle
  assign prod_d    = {{DUTY_W{1'b0}}, tmr_period_i} *
                     {{PERIOD_W{1'b0}}, duty_q[pcnt_q[MIW-1:0]]};
  assign qfull     = {{RECIP_W{1'b0}}, prod_q} * {{PROD_W{1'b0}}, RECIP};
  assign quot      = qfull[PROD_W+RECIP_W-1:RECIP_SHIFT];
  assign pulse_sat = (|quot[QUOT_W-1:PULSE_W]) ? {PULSE_W{1'b1}} : quot[PULSE_W-1:0];
  assign pprev     = pcnt_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '0;
      pcnt_q <= '0;
    end else begin
      unique case (cmd_i)
        OP_LOAD: begin
          duty_q <= {NUM_MOTORS{duty_load_i}};
          pcnt_q <= '0;
        end
        OP_TRIM: begin
          duty_q <= duty_bound;
          pcnt_q <= '0;
        end
        OP_PULSE: begin
          if (pcnt_q != PCNT_END) begin
            pcnt_q <= pcnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == OP_PULSE) begin
      if (pcnt_q < PCNT_END) begin
        prod_q <= prod_d;
      end
      if (pcnt_q != '0) begin
        pulse_q[pprev[MIW-1:0]] <= pulse_sat;
      end
    end
  end

  assign duty_o       = duty_q;
  assign pulse_o      = pulse_q;
  assign pulse_last_o = (pcnt_q == PCNT_END);

endmodule

// ===== sv/gyro_integral_bang_bang_motor_trim.sv =====
`timescale 1ns / 1ps

// Gyro-integral bang-bang motor trim. A tick item (req_type 0) integrates the
// X and Y gyro rates into saturating angles, integrates setpoint minus angle
// into saturating error sums, steps motors C/A on the X sum and D/B on the Y
// sum when a sum leaves +/-1.0, clamps all four duties to duty_offset +/- 3
// and returns the duties with their pulse widths min(65535,
// period*duty/100). A load item (req_type 1) sets all four duties to
// duty_load unclamped. One item is worked at a time. In a tick the error
// passes ceil(ACC_WIDTH/16) times through the 16-bit chunk multiplier; the
// four pulse widths go one motor a cycle through the shared divide-by-100
// path. While the output register still holds a result that is not taken,
// the block waits in its last step. A finished result waits in the output
// register while the next item is already taken. Registers must be written
// only while the block is idle; the block itself does not enforce this.
module gyro_integral_bang_bang_motor_trim #(
  parameter int ACC_WIDTH = 40,
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  gibmt_in_if.sink                             in_i,
  gibmt_out_if.source                          out_o,
  input  logic                                 cfg_we_i,
  input  logic [gibmt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gibmt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import gibmt_pkg::*;

  logic signed [SP_W-1:0]   setpoint_x_q, setpoint_y_q;
  logic [DUTY_W-1:0]        duty_offset_q;
  logic [PERIOD_W-1:0]      tmr_period_q;

  logic signed [RATE_W-1:0] rate_x_q, rate_y_q;
  logic [DUTY_W-1:0]        duty_load_q;
  out_item_t                out_q;

  dp_op_e     cmd;
  dp_status_t status;
  trim_t      trim_x, trim_y;
  logic       mac_last_x, mac_last_y;
  logic       pulse_last;
  duty_vec_t  duty;
  pulse_vec_t pulse;
  logic       in_accept;

  assign in_accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_x_q  <= '0;
      setpoint_y_q  <= '0;
      duty_offset_q <= DUTY_OFFSET_RST;
      tmr_period_q  <= TMR_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SETPOINT_X:  setpoint_x_q  <= cfg_data_i;
        CFG_SETPOINT_Y:  setpoint_y_q  <= cfg_data_i;
        CFG_DUTY_OFFSET: duty_offset_q <= cfg_data_i[DUTY_W-1:0];
        CFG_TMR_PERIOD:  tmr_period_q  <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rate_x_q    <= in_i.payload.rate_x;
      rate_y_q    <= in_i.payload.rate_y;
      duty_load_q <= in_i.payload.duty_load;
    end
    if (cmd == OP_OUT) begin
      out_q.duty_a  <= duty[MOT_A];
      out_q.duty_b  <= duty[MOT_B];
      out_q.duty_c  <= duty[MOT_C];
      out_q.duty_d  <= duty[MOT_D];
      out_q.pulse_a <= pulse[MOT_A];
      out_q.pulse_b <= pulse[MOT_B];
      out_q.pulse_c <= pulse[MOT_C];
      out_q.pulse_d <= pulse[MOT_D];
    end
  end

  assign status.mac_last   = mac_last_x && mac_last_y;
  assign status.pulse_last = pulse_last;

  gibmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .req_type_i  (in_i.payload.req_type),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gibmt_axis #(
    .ACC_WIDTH (ACC_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .rate_i     (rate_x_q),
    .setpoint_i (setpoint_x_q),
    .trim_o     (trim_x),
    .mac_last_o (mac_last_x)
  );

  gibmt_axis #(
    .ACC_WIDTH (ACC_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .rate_i     (rate_y_q),
    .setpoint_i (setpoint_y_q),
    .trim_o     (trim_y),
    .mac_last_o (mac_last_y)
  );

  gibmt_duty u_duty (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .duty_load_i   (duty_load_q),
    .trim_x_i      (trim_x),
    .trim_y_i      (trim_y),
    .duty_offset_i (duty_offset_q),
    .tmr_period_i  (tmr_period_q),
    .duty_o        (duty),
    .pulse_o       (pulse),
    .pulse_last_o  (pulse_last)
  );

  assign out_o.payload = out_q;

endmodule

// ===== sv/gibmt_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gibmt_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input gibmt_pkg::out_item_t out_payload
);
  import gibmt_pkg::*;

  `GIBMT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `GIBMT_ASSERT_HOLD(a_out_stable, out_valid && !out_ready, out_payload, "result changed while stalled")
  `GIBMT_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second item taken while busy")
  `GIBMT_ASSERT(a_no_early_result, in_valid && in_ready && !out_valid |=> !out_valid, "result too early")
  `GIBMT_ASSERT(a_pulse_match, out_valid && (out_payload.duty_a == out_payload.duty_b) |-> out_payload.pulse_a == out_payload.pulse_b, "equal duties gave unequal pulses")

endmodule

bind gyro_integral_bang_bang_motor_trim gibmt_chk u_gibmt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_payload (out_o.payload)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

import gibmt_pkg::*;

class trim_scoreboard;
  localparam int     ACC_W   = 40;
  localparam int     FRAC    = 16;
  localparam longint KDT     = ((longint'(6) << FRAC) + 50) / 100;
  localparam longint ACC_MAX = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint ONE_FX  = longint'(1) << FRAC;

  out_item_t              pending_duties[$];
  longint                 ang_x, ang_y, isum_x, isum_y;
  logic [DUTY_W-1:0]      duty[NUM_MOTORS];
  logic signed [SP_W-1:0] sp_x, sp_y;
  logic [DUTY_W-1:0]      offset;
  logic [PERIOD_W-1:0]    period;
  int                     errors;

  function new();
    ang_x = 0;
    ang_y = 0;
    isum_x = 0;
    isum_y = 0;
    foreach (duty[i]) duty[i] = '0;
    sp_x = '0;
    sp_y = '0;
    offset = DUTY_OFFSET_RST;
    period = TMR_PERIOD_RST;
    errors = 0;
  endfunction

  function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_SETPOINT_X:  sp_x = data[SP_W-1:0];
      CFG_SETPOINT_Y:  sp_y = data[SP_W-1:0];
      CFG_DUTY_OFFSET: offset = data[DUTY_W-1:0];
      default:         period = data[PERIOD_W-1:0];
    endcase
  endfunction

  function longint sat_acc(input longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  // angle, error and integral in fixed point, each product floored
  function void advance_axis(input logic signed [RATE_W-1:0] rate,
                             input logic signed [SP_W-1:0] sp,
                             inout longint ang, inout longint isum);
    longint err;
    ang = sat_acc(ang + ((longint'(rate) * KDT) >>> RATE_FRAC));
    err = sat_acc(longint'(sp) * (longint'(1) << (FRAC - SP_FRAC)) - ang);
    isum = sat_acc(isum + ((err * KDT) >>> FRAC));
  endfunction

  function void nudge(input longint s, input int up, input int down);
    if (s > ONE_FX) begin
      duty[up] += 1;
      duty[down] -= 1;
    end
    if (s < -ONE_FX) begin
      duty[down] += 1;
      duty[up] -= 1;
    end
  endfunction

  // bounds are not wrapped, so one outside 0..255 never matches
  function logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] d);
    int v, hi, lo;
    v = d;
    hi = int'(offset) + 3;
    lo = int'(offset) - 3;
    if (v >= hi) v = hi;
    if (v <= lo) v = lo;
    return DUTY_W'(v);
  endfunction

  function logic [PULSE_W-1:0] pulse_of(input logic [DUTY_W-1:0] d);
    longint p;
    p = longint'(period) * longint'(d) / 100;
    return (p > 65535) ? 16'hffff : PULSE_W'(p);
  endfunction

  function void add_request(input in_item_t r);
    out_item_t e;
    if (r.req_type == REQ_LOAD) begin
      foreach (duty[i]) duty[i] = r.duty_load;
    end else begin
      advance_axis(r.rate_x, sp_x, ang_x, isum_x);
      advance_axis(r.rate_y, sp_y, ang_y, isum_y);
      nudge(isum_x, MOT_C, MOT_A);
      nudge(isum_y, MOT_D, MOT_B);
      foreach (duty[i]) duty[i] = clamp_duty(duty[i]);
    end
    e.duty_a = duty[MOT_A];
    e.duty_b = duty[MOT_B];
    e.duty_c = duty[MOT_C];
    e.duty_d = duty[MOT_D];
    e.pulse_a = pulse_of(duty[MOT_A]);
    e.pulse_b = pulse_of(duty[MOT_B]);
    e.pulse_c = pulse_of(duty[MOT_C]);
    e.pulse_d = pulse_of(duty[MOT_D]);
    pending_duties.push_back(e);
  endfunction

  function void unpack_fields(input out_item_t o, output int unsigned f[8]);
    f[0] = o.duty_a;
    f[1] = o.duty_b;
    f[2] = o.duty_c;
    f[3] = o.duty_d;
    f[4] = o.pulse_a;
    f[5] = o.pulse_b;
    f[6] = o.pulse_c;
    f[7] = o.pulse_d;
  endfunction

  function void check_result(input out_item_t got);
    out_item_t   want;
    int unsigned w[8];
    int unsigned g[8];
    string       label[8] = '{"duty_a", "duty_b", "duty_c", "duty_d",
                              "pulse_a", "pulse_b", "pulse_c", "pulse_d"};
    if (pending_duties.size() == 0) begin
      errors++;
      $display("%0t: unexpected item, expected none, got %h", $time, got);
      return;
    end
    want = pending_duties.pop_front();
    unpack_fields(want, w);
    unpack_fields(got, g);
    for (int i = 0; i < 8; i++) begin
      if (w[i] != g[i]) begin
        errors++;
        $display("%0t: %s expected %0d got %0d", $time, label[i], w[i], g[i]);
      end
    end
  endfunction

  function int pending();
    return pending_duties.size();
  endfunction
endclass

module testbench;
  typedef enum int {RATE_ANY, RATE_UP, RATE_DOWN, RATE_FINE} rate_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  bit                    idle_en;

  gibmt_in_if  in_ch ();
  gibmt_out_if out_ch ();

  trim_scoreboard sb = new();

  gyro_integral_bang_bang_motor_trim dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: check accepted items, stall ready in bursts
  initial begin : result_side
    int stall;
    stall = 0;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
      if (stall > 0) begin
        stall--;
        if (stall == 0) out_ch.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10);
        out_ch.ready <= 1'b0;
      end
    end
  end

  task automatic send_req(input in_item_t r);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= r;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.add_request(r);
  endtask

  task automatic send_tick(input logic signed [RATE_W-1:0] rx, input logic signed [RATE_W-1:0] ry);
    in_item_t r;
    r.req_type = REQ_TICK;
    r.rate_x = rx;
    r.rate_y = ry;
    r.duty_load = DUTY_W'($urandom);
    send_req(r);
  endtask

  task automatic send_load(input logic [DUTY_W-1:0] d);
    in_item_t r;
    r.req_type = REQ_LOAD;
    r.rate_x = RATE_W'($urandom);
    r.rate_y = RATE_W'($urandom);
    r.duty_load = d;
    send_req(r);
  endtask

  // hold off the sender until every expected item has come back
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic reconfigure(input logic [SP_W-1:0] sx, input logic [SP_W-1:0] sy,
                             input logic [DUTY_W-1:0] off, input logic [PERIOD_W-1:0] per);
    quiesce();
    write_reg(CFG_SETPOINT_X, sx);
    write_reg(CFG_SETPOINT_Y, sy);
    write_reg(CFG_DUTY_OFFSET, off);
    write_reg(CFG_TMR_PERIOD, per);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [RATE_W-1:0] pick_rate(input rate_mode_e m);
    case (m)
      RATE_UP:   return RATE_W'($urandom_range(16384, 32767));
      RATE_DOWN: return RATE_W'(-int'($urandom_range(16384, 32768)));
      RATE_FINE: return RATE_W'(int'($urandom_range(0, 127)) - 64);
      default:   return RATE_W'($urandom);
    endcase
  endfunction

  function automatic logic [SP_W-1:0] pick_setpoint();
    case ($urandom_range(0, 5))
      0:       return 24'h7fffff;
      1:       return 24'h800000;
      2, 3:    return SP_W'($urandom_range(0, 1023)) - 24'd512;
      default: return SP_W'($urandom);
    endcase
  endfunction

  function automatic logic [DUTY_W-1:0] pick_offset();
    case ($urandom_range(0, 3))
      0:       return 8'd3;
      1:       return 8'd252;
      default: return DUTY_W'($urandom_range(3, 252));
    endcase
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(0, 4))
      0:       return 16'd1;
      1:       return 16'hffff;
      2:       return PERIOD_W'($urandom_range(1, 200));
      default: return PERIOD_W'($urandom_range(1, 65535));
    endcase
  endfunction

  initial begin : stimulus
    int         ph, k;
    rate_mode_e xm, ym;
    idle_en = 1'b1;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_SETPOINT_X;
    cfg_data_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, rate extremes, clamp at both bounds
    send_tick(16'sd0, 16'sd0);
    send_tick(16'sd32767, -16'sd32768);
    send_tick(-16'sd32768, 16'sd32767);
    send_load(8'd0);
    send_tick(16'sd0, 16'sd0);
    send_load(8'd255);
    send_tick(-16'sd1, -16'sd1);

    // strong trims with duties at the wrap points, pulses saturating
    reconfigure(24'h7fffff, 24'h800000, 8'd252, 16'hffff);
    send_load(8'd255);
    send_tick(16'sd0, 16'sd0);
    send_load(8'd0);
    send_tick(16'sd0, 16'sd0);
    send_load(8'd100);

    // zero period gives zero pulses; low offset puts the lower bound at 0
    reconfigure(24'h800000, 24'h7fffff, 8'd3, 16'd0);
    send_tick(16'sd0, 16'sd0);
    send_load(8'd200);
    send_tick(16'sd16, -16'sd16);

    reconfigure(24'd0, 24'd0, 8'd128, 16'd1);
    send_load(8'd1);
    send_tick(16'sd0, 16'sd0);
    send_load(8'd254);
    send_tick(16'sd1, -16'sd1);
    send_tick(-16'sd32768, -16'sd32768);
    send_tick(16'sd32767, 16'sd32767);

    // x mostly drifts up and y down, so the integrals run far out
    for (ph = 0; ph < 12; ph++) begin
      reconfigure(pick_setpoint(), pick_setpoint(), pick_offset(), pick_period());
      idle_en = (ph < 10) && ($urandom_range(0, 3) != 0);
      xm = ($urandom_range(0, 2) != 0) ? RATE_UP : rate_mode_e'($urandom_range(0, 3));
      ym = ($urandom_range(0, 2) != 0) ? RATE_DOWN : rate_mode_e'($urandom_range(0, 3));
      for (k = 0; k < 150; k++) begin
        if ($urandom_range(0, 199) == 0) quiesce();
        if ($urandom_range(0, 6) == 0) send_load(DUTY_W'($urandom));
        else send_tick(pick_rate(xm), pick_rate(ym));
      end
    end

    quiesce();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
